// ----- src/longest_window_k_distinct_core_defines.svh -----
// ----------------------------------------------------------------------------
// longest_window_k_distinct_core assertion macros
// Shared property forms for the checker, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LONGEST_WINDOW_K_DISTINCT_CORE_DEFINES_SVH
`define LONGEST_WINDOW_K_DISTINCT_CORE_DEFINES_SVH

// same-cycle implication
`define LWKD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LWKD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lwkd_pkg.sv -----
// ----------------------------------------------------------------------------
// lwkd_pkg
// Types and constants shared by the longest k-distinct window core.
// ----------------------------------------------------------------------------
package lwkd_pkg;

    localparam int          DEFAULT_SYMBOL_COUNT = 128;
    localparam int unsigned DEFAULT_MAX_LENGTH   = 32'd65535;

    localparam int SYMBOL_W = 7;
    localparam int LENGTH_W = 16;
    localparam int CFG_W    = 8;

    localparam logic [CFG_W-1:0] MAX_DISTINCT_RESET = 8'd2;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                end_of_string;
    } t_item;

    typedef struct packed {
        logic [LENGTH_W-1:0] window_length;
        logic [LENGTH_W-1:0] best_length;
        logic                overflow;
        logic                is_last;
    } t_result;

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic scan_read;
        logic evict;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic over;
        logic scan_at_end;
        logic out_free;
    } t_status;

endpackage

// ----- src/longest_window_k_distinct_core.sv -----
// Flow: o_stall is high from the taken request until S_IDLE. S_CHECK registers the
// result and o_valid once nothing is to be evicted and the output is free; until then
// each eviction runs S_SCAN, S_DRAIN and S_EVICT, one last-seen memory read per entry.
// Reset: synchronous, active low; clears the window, counters and result
// valid, and sets max_distinct to 2. The last-seen memory is not cleared.
// ----------------------------------------------------------------------------
// longest_window_k_distinct_core
// Streaming longest window with at most max_distinct distinct characters.
// ----------------------------------------------------------------------------
module longest_window_k_distinct_core #(
    parameter int          SYMBOL_COUNT = lwkd_pkg::DEFAULT_SYMBOL_COUNT,
    parameter int unsigned MAX_LENGTH   = lwkd_pkg::DEFAULT_MAX_LENGTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  lwkd_pkg::t_item             i_item,
    output logic                        o_valid,
    input  logic                        i_stall,
    output lwkd_pkg::t_result           o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lwkd_pkg::CFG_W-1:0]  i_cfg_data
);

    lwkd_pkg::t_cmd    cmd;
    lwkd_pkg::t_status status;
    logic              idle;

    lwkd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_idle   (idle)
    );

    lwkd_dpath #(
        .SYMBOL_COUNT (SYMBOL_COUNT),
        .MAX_LENGTH   (MAX_LENGTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_valid && idle),
        .i_cfg_data (i_cfg_data),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    assign o_stall     = !idle;
    assign o_cfg_ready = idle;

endmodule

// ----- src/lwkd_ctrl.sv -----
// ----------------------------------------------------------------------------
// lwkd_ctrl
// Sequencer: request intake, limit check, eviction scan and result release.
// ----------------------------------------------------------------------------
module lwkd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lwkd_pkg::t_status i_status,
    output lwkd_pkg::t_cmd    o_cmd,
    output logic              o_idle
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DRAIN,
        S_EVICT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.over) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_read = 1'b1;
                if (i_status.scan_at_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EVICT;
            end
            S_EVICT: begin
                o_cmd.evict = 1'b1;
                n_state     = S_CHECK;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

// ----- src/lwkd_dpath.sv -----
// ----------------------------------------------------------------------------
// lwkd_dpath
// Window state, last-seen memory, oldest-sighting scan and result register.
// ----------------------------------------------------------------------------
module lwkd_dpath #(
    parameter int          SYMBOL_COUNT = lwkd_pkg::DEFAULT_SYMBOL_COUNT,
    parameter int unsigned MAX_LENGTH   = lwkd_pkg::DEFAULT_MAX_LENGTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lwkd_pkg::t_cmd                 i_cmd,
    output lwkd_pkg::t_status              o_status,
    input  lwkd_pkg::t_item                i_item,
    input  logic                           i_cfg_we,
    input  logic [lwkd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_stall,
    output logic                           o_valid,
    output lwkd_pkg::t_result              o_result
);

    localparam int SYM_W     = $clog2(SYMBOL_COUNT);
    localparam int CNT_W     = $clog2(SYMBOL_COUNT + 1);
    localparam int POS_W     = $clog2(longint'(MAX_LENGTH) + 1);
    localparam int SYM_CODES = 2 ** lwkd_pkg::SYMBOL_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LENGTH);
    localparam logic [SYM_W-1:0] SYM_END = SYM_W'(SYMBOL_COUNT - 1);

    logic [SYM_W-1:0]            sym_map [SYM_CODES];
    logic [POS_W-1:0]            mem [SYMBOL_COUNT];

    logic [SYMBOL_COUNT-1:0]     r_in_window;
    logic [CNT_W-1:0]            r_distinct;
    logic [POS_W-1:0]            r_ws;
    logic [POS_W-1:0]            r_pos;
    logic [POS_W-1:0]            r_best;
    logic                        r_ovf;
    logic                        r_last;
    logic [lwkd_pkg::CFG_W-1:0]  r_max_distinct;
    logic [SYM_W-1:0]            r_scan_idx;
    logic                        r_rd_vld;
    logic [SYM_W-1:0]            r_rd_sym;
    logic [POS_W-1:0]            r_rd_data;
    logic                        r_found;
    logic [POS_W-1:0]            r_oldest;
    logic [SYM_W-1:0]            r_victim;
    logic                        r_out_valid;
    lwkd_pkg::t_result           r_result;

    logic [SYM_W-1:0]            sym_idx;
    logic                        sym_hit;
    logic [POS_W-1:0]            n_pos;
    logic                        n_ovf;
    logic [POS_W-1:0]            seen_pos;
    logic [POS_W-1:0]            n_len;
    logic [POS_W-1:0]            n_best;
    logic                        take_candidate;

    for (genvar g = 0; g < SYM_CODES; g++) begin : g_sym_map
        assign sym_map[g] = SYM_W'(g % SYMBOL_COUNT);
    end

    always_comb begin
        sym_idx = sym_map[i_item.symbol];
        sym_hit = r_in_window[sym_idx];
        if (r_pos >= POS_MAX) begin
            n_pos = POS_MAX;
            n_ovf = 1'b1;
        end else begin
            n_pos = r_pos + 1'b1;
            n_ovf = r_ovf;
        end
        seen_pos = n_pos - 1'b1;
        n_len    = (r_ws <= r_pos) ? (r_pos - r_ws) : '0;
        n_best   = (n_len > r_best) ? n_len : r_best;
        take_candidate = r_rd_vld && r_in_window[r_rd_sym]
                         && (!r_found || (r_rd_data < r_oldest));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            mem[sym_idx] <= seen_pos;
        end
        if (i_cmd.scan_read) begin
            r_rd_data <= mem[r_scan_idx];
            r_rd_sym  <= r_scan_idx;
        end
        if (take_candidate) begin
            r_oldest <= r_rd_data;
            r_victim <= r_rd_sym;
        end
        if (i_cmd.finish) begin
            r_result.window_length <= lwkd_pkg::LENGTH_W'(n_len);
            r_result.best_length   <= lwkd_pkg::LENGTH_W'(n_best);
            r_result.overflow      <= r_ovf;
            r_result.is_last       <= r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_window    <= '0;
            r_distinct     <= '0;
            r_ws           <= '0;
            r_pos          <= '0;
            r_best         <= '0;
            r_ovf          <= 1'b0;
            r_last         <= 1'b0;
            r_max_distinct <= lwkd_pkg::MAX_DISTINCT_RESET;
            r_scan_idx     <= '0;
            r_rd_vld       <= 1'b0;
            r_found        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_distinct <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_pos                <= n_pos;
                r_ovf                <= n_ovf;
                r_last               <= i_item.end_of_string;
                r_in_window[sym_idx] <= 1'b1;
                if (!sym_hit) begin
                    r_distinct <= r_distinct + 1'b1;
                end
            end
            r_rd_vld <= i_cmd.scan_read;
            if (i_cmd.scan_start) begin
                r_scan_idx <= '0;
                r_found    <= 1'b0;
            end else if (i_cmd.scan_read) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
            if (take_candidate) begin
                r_found <= 1'b1;
            end
            if (i_cmd.evict) begin
                r_in_window[r_victim] <= 1'b0;
                r_ws                  <= r_oldest + 1'b1;
                r_distinct            <= r_distinct - 1'b1;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    r_in_window <= '0;
                    r_distinct  <= '0;
                    r_ws        <= '0;
                    r_pos       <= '0;
                    r_best      <= '0;
                    r_ovf       <= 1'b0;
                end else begin
                    r_best      <= n_best;
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.over        = int'(r_distinct) > int'(r_max_distinct);
        o_status.scan_at_end = (r_scan_idx == SYM_END);
        o_status.out_free    = !r_out_valid || !i_stall;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

// ----- src/lwkd_checker.sv -----
// ----------------------------------------------------------------------------
// lwkd_checker
// Port-level checks for the longest k-distinct window core.
// ----------------------------------------------------------------------------
`include "longest_window_k_distinct_core_defines.svh"

module lwkd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input lwkd_pkg::t_result           o_result
);

    `LWKD_ASSERT_NXT(a_busy_after_request, i_valid && !o_stall, o_stall, "no stall after request")
    `LWKD_ASSERT_IMP(a_result_from_busy, $rose(o_valid), $past(o_stall), "result while idle")
    `LWKD_ASSERT_NXT(a_hold, o_valid && i_stall, o_valid && $stable(o_result), "result moved")

endmodule

bind longest_window_k_distinct_core lwkd_checker u_lwkd_checker (.*);

// ----- bench/longest_window_k_distinct_core_test.sv -----
// ----------------------------------------------------------------------------
// longest_window_k_distinct_core_test
// Self-checking bench for the streaming longest k-distinct window core. It
// walks a table of directed requests, then random strings under several
// max_distinct settings and idle/stall mixes. Every result is checked field
// by field against the table row or a local window model, in request order.
// ----------------------------------------------------------------------------
module longest_window_k_distinct_core_test;

    localparam int          SYMBOLS     = lwkd_pkg::DEFAULT_SYMBOL_COUNT;
    localparam int unsigned MAX_POS     = lwkd_pkg::DEFAULT_MAX_LENGTH;
    localparam int          CYCLE_LIMIT = 4_000_000;
    localparam int          PHASE_ITEMS = 300;
    localparam int          PLAN_ROWS   = 22;

    typedef struct packed {
        logic                       is_cfg;
        logic [lwkd_pkg::CFG_W-1:0] cfg;
        lwkd_pkg::t_item            item;
        logic                       typed;
        lwkd_pkg::t_result          want;
    } t_row;

    localparam t_row PLAN [PLAN_ROWS] = '{
        '{1'b0, 8'd0,   '{7'd97,  1'b0}, 1'b1, '{16'd1, 16'd1, 1'b0, 1'b0}},
        '{1'b0, 8'd0,   '{7'd98,  1'b0}, 1'b1, '{16'd2, 16'd2, 1'b0, 1'b0}},
        '{1'b0, 8'd0,   '{7'd97,  1'b0}, 1'b1, '{16'd3, 16'd3, 1'b0, 1'b0}},
        '{1'b0, 8'd0,   '{7'd99,  1'b0}, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0}},
        '{1'b0, 8'd0,   '{7'd99,  1'b0}, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0}},
        '{1'b0, 8'd0,   '{7'd127, 1'b1}, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0}},
        '{1'b0, 8'd0,   '{7'd0,   1'b1}, 1'b1, '{16'd1, 16'd1, 1'b0, 1'b1}},
        '{1'b1, 8'd0,   '{7'd0,   1'b0}, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0}},
        '{1'b0, 8'd0,   '{7'd127, 1'b0}, 1'b1, '{16'd0, 16'd0, 1'b0, 1'b0}},
        '{1'b0, 8'd0,   '{7'd0,   1'b0}, 1'b1, '{16'd0, 16'd0, 1'b0, 1'b0}},
        '{1'b0, 8'd0,   '{7'd85,  1'b1}, 1'b1, '{16'd0, 16'd0, 1'b0, 1'b1}},
        '{1'b1, 8'd128, '{7'd0,   1'b0}, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0}},
        '{1'b0, 8'd0,   '{7'd0,   1'b0}, 1'b1, '{16'd1, 16'd1, 1'b0, 1'b0}},
        '{1'b0, 8'd0,   '{7'd127, 1'b0}, 1'b1, '{16'd2, 16'd2, 1'b0, 1'b0}},
        '{1'b0, 8'd0,   '{7'd42,  1'b0}, 1'b1, '{16'd3, 16'd3, 1'b0, 1'b0}},
        '{1'b0, 8'd0,   '{7'd85,  1'b0}, 1'b1, '{16'd4, 16'd4, 1'b0, 1'b0}},
        '{1'b1, 8'd1,   '{7'd0,   1'b0}, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0}},
        '{1'b0, 8'd0,   '{7'd42,  1'b0}, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0}},
        '{1'b0, 8'd0,   '{7'd42,  1'b1}, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0}},
        '{1'b1, 8'd127, '{7'd0,   1'b0}, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0}},
        '{1'b0, 8'd0,   '{7'd1,   1'b1}, 1'b1, '{16'd1, 16'd1, 1'b0, 1'b1}},
        '{1'b1, 8'd2,   '{7'd0,   1'b0}, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0}}
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    lwkd_pkg::t_item            i_item;
    logic                       o_valid;
    logic                       i_stall;
    lwkd_pkg::t_result          o_result;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [lwkd_pkg::CFG_W-1:0] i_cfg_data;

    longest_window_k_distinct_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // window model state
    bit          present [SYMBOLS];
    int unsigned seen_at [SYMBOLS];
    int          live_count;
    int unsigned start_pos;
    int unsigned char_count;
    int unsigned best_len;
    bit          sat_seen;
    int          limit_model;

    lwkd_pkg::t_result pending_windows [$];

    int          idle_pct;
    int          stall_pct;
    int          mismatch_count;
    int          results_seen;
    int          requests_sent;
    int          cfg_writes;
    int          cycle_count;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_windows.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic void clear_string();
        for (int s = 0; s < SYMBOLS; s++) begin
            present[s] = 1'b0;
            seen_at[s] = 0;
        end
        live_count = 0;
        start_pos  = 0;
        char_count = 0;
        best_len   = 0;
        sat_seen   = 1'b0;
    endfunction

    function automatic lwkd_pkg::t_result window_after(input lwkd_pkg::t_item it);
        int unsigned       sym;
        int unsigned       pos;
        int unsigned       oldest;
        int unsigned       len;
        int                victim;
        lwkd_pkg::t_result r;
        sym = it.symbol % SYMBOLS;
        if (char_count >= MAX_POS) begin
            char_count = MAX_POS;
            sat_seen   = 1'b1;
        end else begin
            char_count++;
        end
        pos = char_count - 1;
        if (!present[sym]) begin
            present[sym] = 1'b1;
            live_count++;
        end
        seen_at[sym] = pos;
        oldest = 0;
        while (live_count > limit_model) begin
            victim = -1;
            for (int s = 0; s < SYMBOLS; s++) begin
                if (present[s] && (victim < 0 || seen_at[s] < oldest)) begin
                    victim = s;
                    oldest = seen_at[s];
                end
            end
            if (victim < 0) break;
            present[victim] = 1'b0;
            start_pos = oldest + 1;
            live_count--;
        end
        len = (start_pos <= char_count) ? char_count - start_pos : 0;
        if (len > best_len) best_len = len;
        r.window_length = len[lwkd_pkg::LENGTH_W-1:0];
        r.best_length   = best_len[lwkd_pkg::LENGTH_W-1:0];
        r.overflow      = sat_seen;
        r.is_last       = it.end_of_string;
        if (it.end_of_string) clear_string();
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s got %0d want %0d",
                 cycle_count, what, got, want);
    endtask

    task automatic compare_field(input string what, input int got, input int want);
        if (got != want) flag_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        lwkd_pkg::t_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            results_seen++;
            if (pending_windows.size() == 0) begin
                flag_mismatch("result with nothing expected", o_result.window_length, 0);
            end else begin
                want = pending_windows.pop_front();
                compare_field("window_length", o_result.window_length, want.window_length);
                compare_field("best_length", o_result.best_length, want.best_length);
                compare_field("overflow", o_result.overflow, want.overflow);
                compare_field("is_last", o_result.is_last, want.is_last);
            end
        end
    end

    task automatic push_request(input lwkd_pkg::t_item it, input logic typed,
                                input lwkd_pkg::t_result want);
        lwkd_pkg::t_result r;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        r = window_after(it);
        if (typed) r = want;
        pending_windows = {pending_windows, r};
        requests_sent++;
    endtask

    task automatic push_symbol(input logic [lwkd_pkg::SYMBOL_W-1:0] sym, input logic last);
        lwkd_pkg::t_item it;
        it.symbol        = sym;
        it.end_of_string = last;
        push_request(it, 1'b0, '0);
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_windows.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_max_distinct(input logic [lwkd_pkg::CFG_W-1:0] value);
        wait_for_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        limit_model = value;
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [lwkd_pkg::CFG_W-1:0] pick_limit();
        unique case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd128;
            2:       return 8'd127;
            3:       return lwkd_pkg::CFG_W'($urandom_range(0, 128));
            default: return lwkd_pkg::CFG_W'($urandom_range(1, 4));
        endcase
    endfunction

    initial begin
        int                            phase_sent;
        int                            len;
        int                            alpha_size;
        logic [lwkd_pkg::SYMBOL_W-1:0] alphabet [8];
        logic [lwkd_pkg::SYMBOL_W-1:0] sym;
        int                            idle_mix [4];
        int                            stall_mix [4];

        idle_mix  = '{0, 50, 0, 15};
        stall_mix = '{0, 0, 50, 15};

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        i_stall     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        mismatch_count = 0;
        results_seen   = 0;
        requests_sent  = 0;
        cfg_writes     = 0;
        cycle_count    = 0;
        limit_model    = lwkd_pkg::MAX_DISTINCT_RESET;
        clear_string();

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < PLAN_ROWS; r++) begin
            if (PLAN[r].is_cfg) load_max_distinct(PLAN[r].cfg);
            else push_request(PLAN[r].item, PLAN[r].typed, PLAN[r].want);
        end

        // random strings under each idle/stall mix
        for (int p = 0; p < 4; p++) begin
            wait_for_results();
            idle_pct   = idle_mix[p];
            stall_pct  = stall_mix[p];
            phase_sent = 0;
            while (phase_sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 3) load_max_distinct(pick_limit());
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                                  : $urandom_range(1, 24);
                alpha_size = $urandom_range(1, 6);
                for (int k = 0; k < 8; k++)
                    alphabet[k] = lwkd_pkg::SYMBOL_W'($urandom_range(0, 127));
                for (int n = 0; n < len; n++) begin
                    if ($urandom_range(0, 99) < 3)
                        load_max_distinct(lwkd_pkg::CFG_W'($urandom_range(0, limit_model)));
                    if ($urandom_range(0, 99) < 15)
                        sym = lwkd_pkg::SYMBOL_W'($urandom_range(0, 127));
                    else sym = alphabet[$urandom_range(0, alpha_size - 1)];
                    push_symbol(sym, n == len - 1);
                    phase_sent++;
                end
            end
        end

        wait_for_results();
        repeat (20) @(posedge i_clk);
        if (pending_windows.size() != 0)
            flag_mismatch("results never delivered", 0, pending_windows.size());

        $display("covered %0d requests and %0d results across %0d limit writes,",
                 requests_sent, results_seen, cfg_writes);
        $display("four idle/stall mixes and limits from zero past the symbol count");
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
